// ===== rtl/satlb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package satlb_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  typedef struct packed {
    logic check;
    logic clearing;
  } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/satlb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module satlb_ram #(
  parameter int DEPTH  = 16,
  parameter int ADR_W  = 4,
  parameter int DATA_W = 162
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADR_W-1:0]  waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADR_W-1:0]  raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/satlb_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none

module satlb_lookup
  import satlb_pkg::*;
#(
  parameter int WAYS  = 4,
  parameter int TAG_W = 39,
  parameter int PTR_W = 2,
  parameter int ADR_W = 4,
  parameter int ROW_W = 162
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_t             ctl,
  input  wire logic [ADR_W-1:0] set_idx,
  input  wire logic [TAG_W-1:0] tag,
  input  wire logic [ROW_W-1:0] rd_row,
  output logic      [ROW_W-1:0] wr_row,
  output logic                  hit,
  output logic      [1:0]       way_used,
  output logic                  done
);

  localparam int VALID_LSB = WAYS * TAG_W;
  localparam int PTR_MSB   = ROW_W - 1;

  logic             fwd_valid;
  logic [ADR_W-1:0] fwd_set;
  logic [ROW_W-1:0] fwd_row;

  logic [ROW_W-1:0] row_cur;
  logic             match_found;
  logic [PTR_W-1:0] match_way;
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_next;
  logic [PTR_W+1:0] way_ext;

  // The row written in the previous cycle is not yet visible in the read data.
  assign row_cur = (fwd_valid && (fwd_set == set_idx)) ? fwd_row : rd_row;
  assign ptr     = row_cur[PTR_MSB -: PTR_W];
  assign ptr_next = (ptr == PTR_W'(WAYS - 1)) ? '0 : ptr + 1'b1;

  always_comb begin
    match_found = 1'b0;
    match_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_cur[VALID_LSB + w] && (row_cur[w*TAG_W +: TAG_W] == tag)) begin
        match_found = 1'b1;
        match_way   = PTR_W'(w);
      end
    end
  end

  always_comb begin
    wr_row = row_cur;
    if (!match_found) begin
      wr_row[ptr*TAG_W +: TAG_W]  = tag;
      wr_row[VALID_LSB + ptr]     = 1'b1;
      wr_row[PTR_MSB -: PTR_W]    = ptr_next;
    end
  end

  assign way_ext = {2'b00, (match_found ? match_way : ptr)};

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      fwd_valid <= ctl.check && !ctl.clearing;
      done      <= ctl.check && !ctl.clearing;
    end
  end

  always_ff @(posedge clk) begin
    fwd_set  <= set_idx;
    fwd_row  <= wr_row;
    hit      <= match_found;
    way_used <= way_ext[1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/set_assoc_tlb_fifo.sv =====
// Channel    Ports                         Direction  Transaction
// --------   ---------------------------   ---------  ----------------------------------
// lookup     start, busy, logical_address  in         start high while busy is low
// result     done, hit, way_used           out        done high for one cycle, no stall
//
// After reset a clearing pass writes every one of the ENTRY_COUNT / WAYS set rows
// (16 with the defaults) once, with busy high.
// Afterwards one lookup is accepted every cycle; its result is registered through the
// s1 stage and the lookup's output register and shows with done.
// Each set is one row of the tag memory and is read and written back once per lookup;
// the row written in the previous cycle is forwarded to the next lookup of the same set.
// The receiver cannot stall, so busy is only high during the clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_tlb_fifo
  import satlb_pkg::*;
#(
  parameter int ENTRY_COUNT = 64,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 21,
  parameter int ADDR_BITS   = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ADDR_BITS-1:0] logical_address,
  output logic                      busy,
  output logic                      done,
  output logic                      hit,
  output logic      [1:0]           way_used
);

  localparam int SETS   = ((ENTRY_COUNT / WAYS) > 0) ? (ENTRY_COUNT / WAYS) : 1;
  localparam int SB     = $clog2(SETS);
  localparam int ADR_W  = (SB > 0) ? SB : 1;
  localparam int TSHIFT = OFFSET_BITS + SB;
  localparam int TAG_W  = (ADDR_BITS > TSHIFT) ? (ADDR_BITS - TSHIFT) : 1;
  localparam int EXT_W  = (ADDR_BITS > TSHIFT) ? ADDR_BITS : (TSHIFT + 1);
  localparam int PTR_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = PTR_W + WAYS + WAYS * TAG_W;

  state_t           state;
  logic [ADR_W-1:0] clr_addr;
  logic             accept;

  logic [EXT_W-1:0] addr_ext;
  logic [ADR_W-1:0] field;
  logic [ADR_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  logic             s1_valid;
  logic [ADR_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;

  logic             ram_we;
  logic [ADR_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wr_row;
  ctl_t             ctl;

  assign busy   = (state == ST_CLEAR);
  assign accept = start && !busy;

  assign addr_ext = EXT_W'(logical_address);
  assign tag_in   = addr_ext[TSHIFT +: TAG_W];

  always_comb begin
    if (SB == 0) begin
      field = '0;
    end else begin
      field = addr_ext[OFFSET_BITS +: ADR_W];
    end
    if ({1'b0, field} >= (ADR_W + 1)'(SETS)) begin
      set_in = field - ADR_W'(SETS);
    end else begin
      set_in = field;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      case (state)
        ST_CLEAR: begin
          if (clr_addr == ADR_W'(SETS - 1)) begin
            state <= ST_RUN;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_set <= set_in;
    s1_tag <= tag_in;
  end

  assign ctl.check    = s1_valid;
  assign ctl.clearing = busy;

  assign ram_we    = busy || s1_valid;
  assign ram_waddr = busy ? clr_addr : s1_set;
  assign ram_wdata = busy ? '0 : wr_row;

  satlb_ram #(
    .DEPTH  (SETS),
    .ADR_W  (ADR_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_in),
    .rdata (rd_row)
  );

  satlb_lookup #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .PTR_W (PTR_W),
    .ADR_W (ADR_W),
    .ROW_W (ROW_W)
  ) u_lookup (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .set_idx  (s1_set),
    .tag      (s1_tag),
    .rd_row   (rd_row),
    .wr_row   (wr_row),
    .hit      (hit),
    .way_used (way_used),
    .done     (done)
  );

endmodule

`default_nettype wire

// ===== dv/tb_set_assoc_tlb_fifo.sv =====
`timescale 1ns / 1ps

module tb_set_assoc_tlb_fifo;

  localparam int NUM_SETS   = 16;
  localparam int NUM_WAYS   = 4;
  localparam int POOL_DEPTH = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    bit       hit;
    bit [1:0] way;
  } tlb_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [63:0] logical_address;
  logic        busy;
  logic        done;
  logic        hit;
  logic [1:0]  way_used;

  bit [38:0]   tag_mem [NUM_SETS*NUM_WAYS];
  bit          entry_valid [NUM_SETS*NUM_WAYS];
  bit [1:0]    fill_ptr [NUM_SETS];
  bit [38:0]   tag_pool [NUM_SETS][POOL_DEPTH];

  tlb_result_t pending_results[$];
  tlb_result_t oldest_result;
  bit          burst_mode;
  int          idle_cycles;
  int          error_count;
  int          lookups_sent;
  int          results_seen;
  int          hit_count;
  int          miss_count;
  int          evict_count;

  set_assoc_tlb_fifo DUT (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .logical_address (logical_address),
    .busy            (busy),
    .done            (done),
    .hit             (hit),
    .way_used        (way_used)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic tlb_result_t tlb_lookup(bit [63:0] addr);
    tlb_result_t res;
    bit [3:0]    set_idx;
    bit [38:0]   tag;
    int          base;
    set_idx = addr[24:21];
    tag     = addr[63:25];
    base    = set_idx * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (entry_valid[base+w] && tag_mem[base+w] == tag) begin
        res.hit = 1'b1;
        res.way = w[1:0];
        hit_count++;
        return res;
      end
    end
    res.hit = 1'b0;
    res.way = fill_ptr[set_idx];
    if (entry_valid[base+res.way]) evict_count++;
    tag_mem[base+res.way]     = tag;
    entry_valid[base+res.way] = 1'b1;
    fill_ptr[set_idx]         = fill_ptr[set_idx] + 2'd1;
    miss_count++;
    return res;
  endfunction

  function automatic bit [63:0] make_address(bit [38:0] tag, bit [3:0] set_idx,
                                             bit [20:0] offset);
    return {tag, set_idx, offset};
  endfunction

  function automatic bit [63:0] random_address(bit narrow);
    bit [3:0]  set_idx;
    int        slot;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (narrow) set_idx = ($urandom_range(0, 1) != 0) ? 4'd3 : 4'd12;
    else set_idx = 4'($urandom_range(0, NUM_SETS-1));
    slot = $urandom_range(0, POOL_DEPTH-1);
    if (pick >= 90) return {$urandom, $urandom};
    if (pick >= 80) tag_pool[set_idx][slot] = 39'({$urandom, $urandom});
    return make_address(tag_pool[set_idx][slot], set_idx, 21'($urandom));
  endfunction

  task automatic send_lookup(input bit [63:0] addr);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    logical_address <= addr;
    do @(posedge clk); while (busy);
    pending_results.push_back(tlb_lookup(addr));
    lookups_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Fills, hits, offset aliasing, FIFO eviction order and extreme address patterns.
  task automatic test_directed();
    burst_mode = 1'b0;
    send_lookup(64'h0);
    send_lookup(64'h0000_0000_001F_FFFF);
    send_lookup(64'hFFFF_FFFF_FFFF_FFFF);
    send_lookup(64'hFFFF_FFFF_FFE0_0000);
    for (int t = 1; t <= 3; t++) send_lookup(make_address(39'(t), 4'd0, 21'd0));
    send_lookup(make_address(39'd1, 4'd0, 21'h1ABCD));
    send_lookup(make_address(39'd4, 4'd0, 21'd0));
    send_lookup(make_address(39'd0, 4'd0, 21'd0));
    send_lookup(make_address(39'd1, 4'd0, 21'd0));
    send_lookup(make_address(39'd4, 4'd0, 21'd7));
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA);
    send_lookup(64'h5555_5555_5555_5555);
    send_lookup(64'hAAAA_AAAA_AAAA_AAAA);
    send_lookup(64'h5555_5555_5555_5555);
    send_lookup(make_address(39'h40_0000_0000, 4'd7, 21'd0));
    send_lookup(make_address(39'h40_0000_0000, 4'd8, 21'h1FFFFF));
    send_lookup(make_address(39'h40_0000_0000, 4'd7, 21'h100000));
    drain_results();
  endtask

  // Back-to-back lookups, mostly to two sets, so consecutive transactions often hit one set.
  task automatic test_back_to_back();
    bit [63:0] addr;
    burst_mode = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i > 0 && $urandom_range(0, 4) == 0) send_lookup(addr);
      else begin
        addr = random_address(1'b1);
        send_lookup(addr);
      end
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 1180; i++) begin
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (i == 600) drain_results();
      send_lookup(random_address($urandom_range(0, 9) == 0));
    end
    burst_mode = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result with no lookup pending, hit=%0b way=%0d", hit, way_used);
        end else begin
          oldest_result = pending_results.pop_front();
          if (hit !== oldest_result.hit || way_used !== oldest_result.way) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("ERROR: result %0d expected hit=%0b way=%0d, got hit=%0b way=%0d",
                       results_seen, oldest_result.hit, oldest_result.way, hit, way_used);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    logical_address = 64'h0;
    for (int s = 0; s < NUM_SETS; s++) begin
      fill_ptr[s] = 2'd0;
      for (int k = 0; k < POOL_DEPTH; k++) tag_pool[s][k] = 39'({$urandom, $urandom});
    end
    for (int e = 0; e < NUM_SETS*NUM_WAYS; e++) begin
      tag_mem[e]     = '0;
      entry_valid[e] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_random_mix();

    drain_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("ERROR: %0d lookups never returned a result", pending_results.size());
    end
    $display("Sent %0d lookups and checked %0d results: %0d hits, %0d misses.",
             lookups_sent, results_seen, hit_count, miss_count);
    $display("Misses that replaced a valid entry: %0d, mismatches: %0d.",
             evict_count, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
